>>> rtl/binary_angle_atan2_top_defines.svh
// Assertion macros for the binary angle arctangent block.
`ifndef BINARY_ANGLE_ATAN2_TOP_DEFINES_SVH
`define BINARY_ANGLE_ATAN2_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define BAT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, checked on clk outside reset.
`define BAT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

>>> rtl/bat_pkg.sv
// Types, constants and the tangent table of the binary angle arctangent block.
package bat_pkg;

	localparam int COORD_W = 19;
	localparam int MAG_W   = 18;
	localparam int ANGLE_W = 8;
	localparam int TAB_LEN = 33;
	localparam int IDX_W   = 6;
	localparam int TAB_W   = 14;
	localparam int TAB_FRAC = 13;

	localparam logic [MAG_W-1:0]   MAG_MAX   = 18'd262143;
	localparam logic [COORD_W-1:0] COORD_MIN = 19'h40000;
	localparam logic [IDX_W-1:0]   TAB_LAST  = 6'd32;
	localparam logic [TAB_W-1:0]   TAN_ONE   = 14'd8192;

	// Axis directions of the negated vector.
	localparam logic [ANGLE_W-1:0] ANG_E = 8'd0;
	localparam logic [ANGLE_W-1:0] ANG_N = 8'd64;
	localparam logic [ANGLE_W-1:0] ANG_W = 8'd128;
	localparam logic [ANGLE_W-1:0] ANG_S = 8'd192;

	// floor(tan(k*2pi/256) * 2^13), last entry exactly one.
	localparam logic [TAB_W-1:0] TAN_Q13 [TAB_LEN] = '{
		14'd0,    14'd201,  14'd402,  14'd604,  14'd806,  14'd1010, 14'd1215,
		14'd1421, 14'd1629, 14'd1839, 14'd2051, 14'd2267, 14'd2485, 14'd2706,
		14'd2931, 14'd3160, 14'd3393, 14'd3631, 14'd3874, 14'd4123, 14'd4378,
		14'd4640, 14'd4910, 14'd5187, 14'd5473, 14'd5769, 14'd6075, 14'd6393,
		14'd6723, 14'd7066, 14'd7424, 14'd7799, 14'd8192
	};

	// Status of an iterative unit toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic [TAB_W-1:0] tan_q13(input logic [IDX_W-1:0] idx);
		logic [TAB_W-1:0] v;
		v = TAN_ONE;
		if (idx <= TAB_LAST) begin
			v = TAN_Q13[idx];
		end
		return v;
	endfunction

endpackage

>>> rtl/bat_in_if.sv
// Input channel of the binary angle arctangent block.
interface bat_in_if
	import bat_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] x_pos;
	logic signed [COORD_W-1:0] y_pos;
	logic        [ANGLE_W-1:0] zero_angle;

	modport source (output valid, output x_pos, output y_pos, output zero_angle,
		input ready);
	modport sink (input valid, input x_pos, input y_pos, input zero_angle,
		output ready);
endinterface

>>> rtl/bat_out_if.sv
// Result channel of the binary angle arctangent block.
interface bat_out_if
	import bat_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

>>> rtl/bat_div.sv
// Restoring divider, one quotient bit per cycle: q = (mag_lo << (QW-1)) / mag_hi.
module bat_div
	import bat_pkg::*;
#(
	parameter int QW = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] mag_lo,
	input  logic [MAG_W-1:0] mag_hi,
	output logic [QW-1:0]    q,
	output unit_stat_t       stat
);
	localparam int CW = $clog2(QW + 1);

	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] large_q;
	logic [QW-1:0]    quo_q;
	logic [CW-1:0]    cnt_q;
	logic             first_q;
	logic             busy_q;
	logic             done_q;

	logic [MAG_W:0] trial;
	logic [MAG_W:0] diff;
	logic           ge;

	// First step compares the remainder itself, later steps its double.
	assign trial = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign ge    = trial >= {1'b0, large_q};
	assign diff  = trial - {1'b0, large_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= CW'(QW);
				first_q <= 1'b1;
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= mag_lo;
			large_q <= mag_hi;
			quo_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign q         = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

>>> rtl/bat_search.sv
// Linear tangent table search, one entry compared per cycle.
module bat_search
	import bat_pkg::*;
#(
	parameter int FRAC_BITS = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FRAC_BITS:0] q,
	output logic [IDX_W-1:0]  k,
	output unit_stat_t        stat
);
	localparam int SHIFT = TAB_FRAC - FRAC_BITS;

	logic [FRAC_BITS:0] q_q;
	logic [IDX_W-1:0]   k_q;
	logic               busy_q;
	logic               done_q;

	logic [TAB_W-1:0] entry;
	logic [TAB_W-1:0] q_ext;
	logic             advance;

	assign entry   = tan_q13(k_q) >> SHIFT;
	assign q_ext   = TAB_W'(q_q);
	assign advance = (k_q < TAB_LAST) && (q_ext > entry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= !start && busy_q && !advance;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				if (advance) begin
					k_q <= k_q + 1'b1;
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= q;
		end
	end

	assign k         = k_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

>>> rtl/binary_angle_atan2_top.sv
// Top level of the binary angle arctangent block: sequencer, octant fold, result register.
//
// Usage: the input channel carries a signed (x_pos, y_pos) pair and a fallback
// angle; the result channel returns the direction of (-x_pos, -y_pos) as an
// 8-bit binary angle, 256 steps per turn. Both channels use valid/ready; an
// item moves on a clock edge with both high.
// Timing: the block takes one item at a time. An item on an axis or at the
// origin is resolved in the accept cycle and passes through the done state
// into the output register. Any other item runs a restoring divide of
// TAN_FRACTION_BITS+1 quotient bits, one quotient bit per cycle, then a linear
// tangent table search over at most 33 entries, one entry per cycle, before
// the done state. The input is ready again once the result has moved into the
// output register.
// Stall: a result waits in the output register while the receiver holds
// ready low; a next item may be accepted and worked on meanwhile, and its
// result waits in the sequencer until the output register frees up.
// Reset: arst_n clears the sequencer and the output valid; no clearing pass.
`include "binary_angle_atan2_top_defines.svh"

module binary_angle_atan2_top
	import bat_pkg::*;
#(
	parameter int TAN_FRACTION_BITS = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	bat_in_if.sink           in_ch,
	bat_out_if.source        out_ch
);
	localparam int QW = TAN_FRACTION_BITS + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_SRCH = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [ANGLE_W-1:0] base_q;
	logic               sub_q;
	logic [ANGLE_W-1:0] res_q;
	logic               out_valid_q;
	logic [ANGLE_W-1:0] angle_q;

	logic               acc;
	logic [MAG_W-1:0]   ax;
	logic [MAG_W-1:0]   ay;
	logic               xp;
	logic               yp;
	logic               gt;
	logic               special;
	logic [ANGLE_W-1:0] special_ang;
	logic [ANGLE_W-1:0] base_d;
	logic               sub_d;
	logic [MAG_W-1:0]   mag_lo;
	logic [MAG_W-1:0]   mag_hi;
	logic               out_free;

	logic [QW-1:0]    quo;
	logic [IDX_W-1:0] k;
	unit_stat_t       div_stat;
	unit_stat_t       srch_stat;

	assign in_ch.ready = (state_q == S_IDLE);
	assign acc         = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// Magnitudes with the most negative code saturated.
	always_comb begin
		ax = in_ch.x_pos[COORD_W-1]
			? ((in_ch.x_pos == COORD_MIN) ? MAG_MAX : MAG_W'(-in_ch.x_pos))
			: MAG_W'(in_ch.x_pos);
		ay = in_ch.y_pos[COORD_W-1]
			? ((in_ch.y_pos == COORD_MIN) ? MAG_MAX : MAG_W'(-in_ch.y_pos))
			: MAG_W'(in_ch.y_pos);
	end

	// Negated vector: X > 0 where x_pos < 0, likewise for Y.
	assign xp = in_ch.x_pos[COORD_W-1];
	assign yp = in_ch.y_pos[COORD_W-1];
	assign gt = ax > ay;

	assign mag_lo = gt ? ay : ax;
	assign mag_hi = gt ? ax : ay;

	// Origin and axes bypass the divider.
	always_comb begin
		special     = 1'b1;
		special_ang = in_ch.zero_angle;
		priority if (ax == '0 && ay == '0) begin
			special_ang = in_ch.zero_angle;
		end else if (ax == '0) begin
			special_ang = yp ? ANG_N : ANG_S;
		end else if (ay == '0) begin
			special_ang = xp ? ANG_E : ANG_W;
		end else begin
			special = 1'b0;
		end
	end

	// Octant fold: base angle and whether the search index counts back.
	always_comb begin
		unique case ({xp, yp})
			2'b11: begin
				base_d = gt ? ANG_E : ANG_N;
				sub_d  = !gt;
			end
			2'b01: begin
				base_d = gt ? ANG_W : ANG_N;
				sub_d  = gt;
			end
			2'b00: begin
				base_d = gt ? ANG_W : ANG_S;
				sub_d  = !gt;
			end
			default: begin
				base_d = gt ? ANG_E : ANG_S;
				sub_d  = gt;
			end
		endcase
	end

	bat_div #(
		.QW(QW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (acc && !special),
		.mag_lo(mag_lo),
		.mag_hi(mag_hi),
		.q     (quo),
		.stat  (div_stat)
	);

	bat_search #(
		.FRAC_BITS(TAN_FRACTION_BITS)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_stat.done),
		.q     (quo),
		.k     (k),
		.stat  (srch_stat)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished result, else drop the one the receiver took.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= special ? S_DONE : S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (srch_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			base_q <= base_d;
			sub_q  <= sub_d;
			res_q  <= special_ang;
		end else if (srch_stat.done) begin
			res_q <= sub_q ? (base_q - ANGLE_W'(k)) : (base_q + ANGLE_W'(k));
		end
		if (state_q == S_DONE && out_free) begin
			angle_q <= res_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.angle = angle_q;

	// Divider finishes only while the sequencer waits on it.
	`BAT_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == S_DIV)
	// Search finishes only while the sequencer waits on it.
	`BAT_ASSERT_IMP(a_srch_done_in_srch, srch_stat.done, state_q == S_SRCH)
	// A general item leaves the divider busy and the sequencer in S_DIV on the next cycle.
	`BAT_ASSERT_NXT(a_acc_starts_div, acc && !special, div_stat.busy && state_q == S_DIV)
	// A new result is loaded only from the done state.
	`BAT_ASSERT_IMP(a_load_from_done, $rose(out_valid_q), $past(state_q == S_DONE))
	// Search index never runs past the last table entry.
	`BAT_ASSERT_IMP(a_k_in_table, srch_stat.busy, k <= TAB_LAST)
endmodule

>>> sim/bat_atan2_checker.sv
// Checker for the binary angle arctangent block: predicts each angle and compares results.
`timescale 1ns / 1ps

module bat_atan2_checker
	import bat_pkg::*;
#(
	parameter int FRAC = 13
) (
	input  logic clk,
	input  logic arst_n,
	bat_in_if    in_mon,
	bat_out_if   out_mon,
	output int   mismatches,
	output int   backlog
);

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic        [ANGLE_W-1:0] zero_angle;
		logic        [ANGLE_W-1:0] angle;
	} angle_expect_t;

	// tan(k * 2pi / 256) in Q13, last entry exactly one
	localparam int TAN_TABLE [33] = '{
		0, 201, 402, 604, 806, 1010, 1215, 1421, 1629, 1839, 2051,
		2267, 2485, 2706, 2931, 3160, 3393, 3631, 3874, 4123, 4378,
		4640, 4910, 5187, 5473, 5769, 6075, 6393, 6723, 7066, 7424,
		7799, 8192
	};

	angle_expect_t expected_angles[$];
	int            err_count = 0;
	int            queued    = 0;

	assign mismatches = err_count;
	assign backlog    = queued;

	// first table index whose entry is not below (small << FRAC) / large
	function automatic int tan_index(input int small_mag, input int large_mag);
		longint ratio;
		int     k;
		ratio = (longint'(small_mag) << FRAC) / longint'(large_mag);
		k = 0;
		while (k < 32 && ratio > longint'(TAN_TABLE[k] >>> (13 - FRAC)))
			k++;
		return k;
	endfunction

	function automatic logic [ANGLE_W-1:0] predict_angle(
		input logic signed [COORD_W-1:0] xp,
		input logic signed [COORD_W-1:0] yp,
		input logic        [ANGLE_W-1:0] za
	);
		int xs, ys, vx, vy, ax, ay, a;
		xs = int'(xp);
		ys = int'(yp);
		if (xs < -262143) xs = -262143;
		if (ys < -262143) ys = -262143;
		vx = -xs;
		vy = -ys;
		ax = (vx < 0) ? -vx : vx;
		ay = (vy < 0) ? -vy : vy;
		if (vx == 0 && vy == 0)
			a = int'(za);
		else if (vx == 0)
			a = (vy > 0) ? 64 : 192;
		else if (vy == 0)
			a = (vx > 0) ? 0 : 128;
		else if (vx > 0 && vy > 0)
			a = (ax > ay) ? tan_index(ay, ax) : 64 - tan_index(ax, ay);
		else if (vx < 0 && vy > 0)
			a = (ax <= ay) ? 64 + tan_index(ax, ay) : 128 - tan_index(ay, ax);
		else if (vx < 0)
			a = (ax > ay) ? 128 + tan_index(ay, ax) : 192 - tan_index(ax, ay);
		else
			a = (ax <= ay) ? 192 + tan_index(ax, ay) : 256 - tan_index(ay, ax);
		return a[ANGLE_W-1:0];
	endfunction

	task automatic flag_error(input string what);
		if (err_count < 10)
			$display("%0t: %s", $realtime, what);
		err_count++;
	endtask

	always @(posedge clk) begin
		angle_expect_t head, fresh;
		if (arst_n) begin
			// retire the result first: it always belongs to an older item
			if (out_mon.valid && out_mon.ready) begin
				if (expected_angles.size() == 0) begin
					flag_error($sformatf("unexpected angle %0d with nothing pending",
						out_mon.angle));
				end else begin
					head = expected_angles.pop_front();
					if (out_mon.angle !== head.angle)
						flag_error($sformatf(
							"angle mismatch x=%0d y=%0d zero=%0d: expected %0d, got %0d",
							head.x, head.y, head.zero_angle, head.angle, out_mon.angle));
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				fresh.x          = in_mon.x_pos;
				fresh.y          = in_mon.y_pos;
				fresh.zero_angle = in_mon.zero_angle;
				fresh.angle      = predict_angle(in_mon.x_pos, in_mon.y_pos, in_mon.zero_angle);
				expected_angles.push_back(fresh);
			end
			queued <= expected_angles.size();
		end
	end

endmodule

>>> sim/binary_angle_atan2_top_tb.sv
// Testbench top for the binary angle arctangent block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module binary_angle_atan2_top_tb;
	import bat_pkg::*;

	localparam int FRAC       = 13;
	// Cycles with no item moving on either channel before the run is declared hung.
	// Worst correct case is the work on one item plus a long sender gap and a long
	// receiver stall.
	localparam int QUIET_MAX  = 4000;
	// Drain time after the last expected angle, about one item's worth of work.
	localparam int DRAIN_CYC  = 64;
	localparam int PHASE_ITEMS = 113;

	logic clk;
	logic arst_n     = 1'b0;
	logic sink_ready = 1'b0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   quiet_cycles   = 0;
	int   mismatches;
	int   backlog;

	bat_in_if  in_bus ();
	bat_out_if out_bus ();

	assign out_bus.ready = sink_ready;

	binary_angle_atan2_top #(
		.TAN_FRACTION_BITS(FRAC)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	bat_atan2_checker #(
		.FRAC(FRAC)
	) angle_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_bus),
		.out_mon    (out_bus),
		.mismatches (mismatches),
		.backlog    (backlog)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: drop ready at random according to the current stall rate.
	always @(posedge clk) begin
		sink_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Watchdog: count cycles in which no item moves on either side.
	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one item; hold it until the block takes it. Idle first at the
	// current sender rate, lowering valid only once for the whole gap.
	task automatic send_coords(
		input logic signed [COORD_W-1:0] xv,
		input logic signed [COORD_W-1:0] yv,
		input logic        [ANGLE_W-1:0] za
	);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_bus.valid      <= 1'b1;
		in_bus.x_pos      <= xv;
		in_bus.y_pos      <= yv;
		in_bus.zero_angle <= za;
		do @(posedge clk); while (!in_bus.ready);
	endtask

	// Hold valid low until every predicted angle has come back.
	task automatic drain_angles();
		in_bus.valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
	endtask

	// Random coordinate pair, weighted toward the interesting regions: full-range
	// noise, tiny vectors, near-diagonals, axes, saturation, and ratios that sit
	// right on a tangent table boundary.
	task automatic pick_coords(
		output logic signed [COORD_W-1:0] xo,
		output logic signed [COORD_W-1:0] yo
	);
		int     a, b, k, tmp;
		longint s;
		bit     raw;
		raw = 1'b0;
		a = 0;
		b = 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				raw = 1'b1;
				xo  = COORD_W'($urandom);
				yo  = COORD_W'($urandom);
			end
			4: begin
				a = int'($urandom_range(0, 40)) - 20;
				b = int'($urandom_range(0, 40)) - 20;
			end
			5: begin
				a = $urandom_range(1, 262143);
				b = a + int'($urandom_range(0, 4)) - 2;
				if (b > 262143) b = 262143;
			end
			6: begin
				a = ($urandom_range(0, 3) == 0) ? 262143 : int'($urandom_range(1, 262143));
				if ($urandom_range(0, 1)) begin
					tmp = a;
					a = b;
					b = tmp;
				end
			end
			7: begin
				raw = 1'b1;
				case ($urandom_range(0, 3))
					0: begin
						xo = '0;
						yo = '0;
					end
					1: begin
						xo = COORD_MIN;
						yo = COORD_W'($urandom);
					end
					2: begin
						xo = COORD_W'($urandom);
						yo = COORD_MIN;
					end
					default: begin
						xo = COORD_MIN;
						yo = $urandom_range(0, 1) ? COORD_MIN : '0;
					end
				endcase
			end
			8: begin
				b = $urandom_range(1, 262143);
				k = $urandom_range(0, 32);
				s = (longint'(TAN_Q13[k]) * longint'(b)) >>> 13;
				a = int'(s) + int'($urandom_range(0, 2)) - 1;
				if (a < 0) a = 0;
				if (a > b) a = b;
				if ($urandom_range(0, 1)) begin
					tmp = a;
					a = b;
					b = tmp;
				end
			end
			default: begin
				a = $urandom_range(0, 1) ? 262143 : int'($urandom_range(0, 262143));
				b = $urandom_range(0, 1) ? 262143 : int'($urandom_range(0, 15));
			end
		endcase
		if (!raw) begin
			xo = COORD_W'($urandom_range(0, 1) ? -a : a);
			yo = COORD_W'($urandom_range(0, 1) ? -b : b);
		end
	endtask

	// Directed items: origin with several fallbacks, every axis both ways,
	// saturation of the most negative value, equal magnitudes in each quadrant,
	// and the smallest nonzero ratio in every octant.
	int dir_x [25] = '{0, 0, 0, -1, 1, 0, 0, -262144, 0, 262143, 0, -262144, 262143,
		-5, 5, -262143, -1, 262143, 1, -262143, 262143, 1, -1, -262144, 3};
	int dir_y [25] = '{0, 0, 0, 0, 0, -1, 1, 0, -262144, 0, 262143, -262144, 262143,
		5, -5, -1, -262143, -1, 262143, 1, 1, -262143, 262143, 262143, -7};
	int dir_z [3] = '{0, 255, 165};

	// Sender idle and receiver stall rates, one pair per phase.
	int phase_send  [4] = '{0, 78, 0, 36};
	int phase_stall [4] = '{0, 0, 78, 36};

	initial begin
		logic signed [COORD_W-1:0] xr, yr;
		logic        [ANGLE_W-1:0] zr;
		in_bus.valid      = 1'b0;
		in_bus.x_pos      = '0;
		in_bus.y_pos      = '0;
		in_bus.zero_angle = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		for (int i = 0; i < 25; i++) begin
			zr = (i < 3) ? ANGLE_W'(dir_z[i]) : ANGLE_W'($urandom);
			send_coords(COORD_W'(dir_x[i]), COORD_W'(dir_y[i]), zr);
		end

		// random part across the idle/stall phases
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = phase_send[p];
			recv_stall_pct = phase_stall[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick_coords(xr, yr);
				zr = ANGLE_W'($urandom);
				send_coords(xr, yr, zr);
				// pause once per phase until the block has emptied out
				if (i == PHASE_ITEMS / 2)
					drain_angles();
			end
		end

		drain_angles();
		repeat (DRAIN_CYC) @(posedge clk);

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/bat_pkg.sv
rtl/bat_in_if.sv
rtl/bat_out_if.sv
rtl/bat_div.sv
rtl/bat_search.sv
rtl/binary_angle_atan2_top.sv
sim/bat_atan2_checker.sv
sim/binary_angle_atan2_top_tb.sv
